// ===== rtl/crcdf_pkg.sv =====
// shared types and constants for the crc32 frame deframer
`timescale 1ns / 1ps

package crcdf_pkg;

    // start flag "GUIM", big-endian as it arrives on the wire
    localparam logic [31:0] FLAG_WORD = 32'h4755494D;
    // reflected crc-32 polynomial
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [15:0] SKIP_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ID      = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } kind_t;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_MISMATCH = 1'b1
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] message_id;
        logic [31:0] payload_length;
        logic        status;
        logic [15:0] skipped_count;
    } result_t;

endpackage

// ===== rtl/crcdf_crc_byte.sv =====
// byte-wise crc-32 update, reflected polynomial
`timescale 1ns / 1ps

module crcdf_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import crcdf_pkg::*;

    logic [31:0] c;

    always_comb begin
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/crc32_frame_deframer_unit.sv =====
// top level of the start-flag / length / crc-32 byte stream deframer
`timescale 1ns / 1ps

// channel   direction  ports                                     one request carries
// s_        in         s_valid s_ready s_data_byte               one stream byte
// m_        out        m_valid m_ready m_kind m_payload_byte     one payload byte or
//                      m_message_id m_payload_length m_status    one frame-end summary
//                      m_skipped_count
//
// one byte per cycle while s_ready is high: the frame state and the running crc
// (one byte-wide crc update) settle at the edge that accepts a byte, and any result
// lands in the output stage (output register, or skid register if that is busy) at
// that same edge, so with a free output register it shows on m_ the cycle after.
// reset (aresetn low, synchronous) puts the block into flag hunting with an
// empty output stage.
// a two-entry output stage (output register plus skid register) keeps s_ready
// high while one result waits; s_ready drops only when both entries are full.

module crc32_frame_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [31:0] m_message_id,
    output logic [31:0] m_payload_length,
    output logic        m_status,
    output logic [15:0] m_skipped_count
);
    import crcdf_pkg::*;

    // frame state
    phase_t      phase_reg,  phase_next;
    logic [31:0] window_reg, window_next;      // last four bytes while hunting
    logic [1:0]  fcnt_reg,   fcnt_next;        // bytes taken of current 4-byte field
    logic [31:0] id_reg,     id_next;
    logic [31:0] len_reg,    len_next;
    logic [31:0] remain_reg, remain_next;      // payload bytes still to come
    logic [31:0] crc_reg,    crc_next;         // running crc, not yet inverted
    logic [31:0] rxcrc_reg,  rxcrc_next;       // crc field as received
    logic [15:0] skip_reg,   skip_next;        // discarded bytes, saturating

    // output stage
    result_t     main_reg,   main_next;
    logic        main_valid_reg, main_valid_next;
    result_t     skid_reg,   skid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        accept;
    logic        pop;
    logic        push;
    logic        res_valid;
    result_t     res;
    logic [31:0] crc_upd;
    logic [31:0] window_shift;
    logic [31:0] len_shift;
    logic [31:0] rxcrc_shift;

    assign s_ready = ~skid_valid_reg;
    assign accept  = s_valid & s_ready;
    assign pop     = main_valid_reg & m_ready;
    assign push    = accept & res_valid;

    assign window_shift = {window_reg[23:0], s_data_byte};
    assign len_shift    = {len_reg[23:0], s_data_byte};
    assign rxcrc_shift  = {rxcrc_reg[23:0], s_data_byte};

    // crc of the running value with the incoming byte
    crcdf_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (s_data_byte),
        .crc_out (crc_upd)
    );

    // next frame state
    always_comb begin
        phase_next  = phase_reg;
        window_next = window_reg;
        fcnt_next   = fcnt_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        crc_next    = crc_reg;
        rxcrc_next  = rxcrc_reg;
        skip_next   = skip_reg;

        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    window_next = window_shift;
                    if (window_shift == FLAG_WORD) begin
                        phase_next = PH_ID;
                        fcnt_next  = 2'd0;
                        crc_next   = CRC_INIT;
                    end else if (fcnt_reg == 2'd3) begin
                        // the first three bytes are never counted as skipped
                        if (skip_reg != SKIP_MAX) begin
                            skip_next = skip_reg + 16'd1;
                        end
                    end else begin
                        fcnt_next = fcnt_reg + 2'd1;
                    end
                end
                PH_ID: begin
                    id_next   = {id_reg[23:0], s_data_byte};
                    crc_next  = crc_upd;
                    fcnt_next = fcnt_reg + 2'd1;
                    if (fcnt_reg == 2'd3) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    len_next  = len_shift;
                    crc_next  = crc_upd;
                    fcnt_next = fcnt_reg + 2'd1;
                    if (fcnt_reg == 2'd3) begin
                        remain_next = len_shift;
                        // zero length goes straight to the crc field
                        phase_next  = (len_shift == 32'd0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc_next    = crc_upd;
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1) begin
                        fcnt_next  = 2'd0;
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC: begin
                    rxcrc_next = rxcrc_shift;
                    fcnt_next  = fcnt_reg + 2'd1;
                    if (fcnt_reg == 2'd3) begin
                        // frame done: clear everything and hunt again
                        phase_next  = PH_HUNT;
                        window_next = 32'd0;
                        fcnt_next   = 2'd0;
                        id_next     = 32'd0;
                        len_next    = 32'd0;
                        remain_next = 32'd0;
                        crc_next    = CRC_INIT;
                        rxcrc_next  = 32'd0;
                        skip_next   = 16'd0;
                    end
                end
                default: begin
                    phase_next  = PH_HUNT;
                    window_next = 32'd0;
                    fcnt_next   = 2'd0;
                    id_next     = 32'd0;
                    len_next    = 32'd0;
                    remain_next = 32'd0;
                    crc_next    = CRC_INIT;
                    rxcrc_next  = 32'd0;
                    skip_next   = 16'd0;
                end
            endcase
        end
    end

    // result for the byte at the input
    always_comb begin
        res_valid          = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.message_id     = id_reg;
        res.payload_length = len_reg;
        res.status         = STATUS_OK;
        res.skipped_count  = skip_reg;

        case (phase_reg)
            PH_PAYLOAD: begin
                res_valid        = 1'b1;
                res.payload_byte = s_data_byte;
            end
            PH_CRC: begin
                if (fcnt_reg == 2'd3) begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_FRAME_END;
                    res.status = (rxcrc_shift != ~crc_reg) ? STATUS_MISMATCH : STATUS_OK;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // output register plus skid register
    always_comb begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!main_valid_reg) begin
            main_next       = res;
            main_valid_next = push;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_next       = res;
                skid_valid_next = push;
            end else begin
                main_next       = res;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            window_reg     <= 32'd0;
            fcnt_reg       <= 2'd0;
            id_reg         <= 32'd0;
            len_reg        <= 32'd0;
            remain_reg     <= 32'd0;
            crc_reg        <= CRC_INIT;
            rxcrc_reg      <= 32'd0;
            skip_reg       <= 16'd0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            fcnt_reg       <= fcnt_next;
            id_reg         <= id_next;
            len_reg        <= len_next;
            remain_reg     <= remain_next;
            crc_reg        <= crc_next;
            rxcrc_reg      <= rxcrc_next;
            skip_reg       <= skip_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload of the output stage, no reset needed
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = main_valid_reg;
    assign m_kind           = main_reg.kind;
    assign m_payload_byte   = main_reg.payload_byte;
    assign m_message_id     = main_reg.message_id;
    assign m_payload_length = main_reg.payload_length;
    assign m_status         = main_reg.status;
    assign m_skipped_count  = main_reg.skipped_count;

endmodule
